[src/wsc_pkg.sv]
// wsc_pkg: shared types for the window SSD corner marker.
// Request/result payload structs and the engine geometry struct.
// No dependencies.
`timescale 1ns / 1ps
package wsc_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam int unsigned ScoreW = 24;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HALF   = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel;
  } wsc_req_t;

  typedef struct packed {
    logic [9:0]        col;
    logic [8:0]        row;
    logic [ScoreW-1:0] score;
    logic              corner;
    logic              last;
  } wsc_res_t;

  // geometry and kick from top level to the score engine
  typedef struct packed {
    logic       start;
    logic [9:0] w;
    logic [8:0] h;
    logic [2:0] half;
  } wsc_geom_t;

endpackage

[src/wsc_mem.sv]
// wsc_mem: simple dual-port synchronous RAM, one write and one read port.
// Read data registered. No dependencies.
`timescale 1ns / 1ps
module wsc_mem #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/wsc_engine.sv]
// wsc_engine: sweeps all interior positions column-outer, reads each window
// from the pixel RAM one pixel a cycle, writes the score RAM, tracks the max.
// Depends on wsc_pkg.
`timescale 1ns / 1ps
module wsc_engine #(
  parameter int unsigned AW = 19
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wsc_pkg::wsc_geom_t        geom_i,
  output logic [AW-1:0]             pix_raddr_o,
  input  logic [7:0]                pix_rdata_i,
  output logic                      sc_we_o,
  output logic [AW-1:0]             sc_waddr_o,
  output logic [wsc_pkg::ScoreW-1:0] sc_wdata_o,
  output logic                      done_o,
  output logic [wsc_pkg::ScoreW-1:0] max_o
);
  import wsc_pkg::*;

  typedef enum logic [7:0] {
    E_IDLE  = 8'b0000_0001,
    E_CADDR = 8'b0000_0010,
    E_CRD   = 8'b0000_0100,
    E_CWAIT = 8'b0000_1000,
    E_WIN   = 8'b0001_0000,
    E_DRAIN = 8'b0010_0000,
    E_WRITE = 8'b0100_0000,
    E_NEXT  = 8'b1000_0000
  } eng_state_e;

  eng_state_e state_q, state_d;

  logic [9:0]        w_q, c_q;
  logic [8:0]        h_q, r_q;
  logic [2:0]        k_q;
  logic [3:0]        ws_q, x_q, y_q;
  logic [AW-1:0]     ctr_addr_q, wa_q, xs_q;
  logic [7:0]        ctr_pix_q;
  logic [ScoreW-1:0] acc_q, max_q;
  logic              vld_q, done_q;

  logic [3:0]  ws_new;
  logic        empty;
  logic [7:0]  diff;
  logic [15:0] sq;
  logic [AW-1:0] kw_off;

  assign ws_new = {geom_i.half, 1'b1};
  assign empty  = (geom_i.w <= {5'd0, ws_new, 1'b0}) || (geom_i.h <= {4'd0, ws_new, 1'b0});
  assign diff   = (pix_rdata_i > ctr_pix_q) ? pix_rdata_i - ctr_pix_q
                                            : ctr_pix_q - pix_rdata_i;
  assign sq     = diff * diff;
  assign kw_off = AW'(k_q) * AW'(w_q) + AW'(k_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE:  if (geom_i.start && !empty) state_d = E_CADDR;
      E_CADDR: state_d = E_CRD;
      E_CRD:   state_d = E_CWAIT;
      E_CWAIT: state_d = E_WIN;
      E_WIN:   if (x_q == ws_q - 4'd1 && y_q == ws_q - 4'd1) state_d = E_DRAIN;
      E_DRAIN: state_d = E_WRITE;
      E_WRITE: state_d = E_NEXT;
      E_NEXT: begin
        if (r_q + 9'd1 == h_q - {5'd0, ws_q} && c_q + 10'd1 == w_q - {6'd0, ws_q}) begin
          state_d = E_IDLE;
        end else begin
          state_d = E_CADDR;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      vld_q   <= 1'b0;
      done_q  <= 1'b0;
      max_q   <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= (state_q == E_WIN);
      done_q  <= 1'b0;
      if (state_q == E_IDLE && geom_i.start) begin
        max_q <= '0;
        if (empty) done_q <= 1'b1;
      end
      if (state_q == E_WRITE && acc_q > max_q) max_q <= acc_q;
      if (state_q == E_NEXT && state_d == E_IDLE) done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      E_IDLE: begin
        w_q  <= geom_i.w;
        h_q  <= geom_i.h;
        k_q  <= geom_i.half;
        ws_q <= ws_new;
        c_q  <= {6'd0, ws_new};
        r_q  <= {5'd0, ws_new};
      end
      E_CADDR: ctr_addr_q <= AW'(r_q) * AW'(w_q) + AW'(c_q);
      E_CRD: begin
        wa_q <= ctr_addr_q - kw_off;
        xs_q <= ctr_addr_q - kw_off;
        x_q  <= '0;
        y_q  <= '0;
      end
      E_CWAIT: begin
        ctr_pix_q <= pix_rdata_i;
      end
      E_WIN: begin
        // y inner: step one row down; at window bottom move to next column top
        if (y_q == ws_q - 4'd1) begin
          y_q  <= '0;
          x_q  <= x_q + 4'd1;
          xs_q <= xs_q + AW'(1);
          wa_q <= xs_q + AW'(1);
        end else begin
          y_q  <= y_q + 4'd1;
          wa_q <= wa_q + AW'(w_q);
        end
      end
      E_NEXT: begin
        if (r_q + 9'd1 == h_q - {5'd0, ws_q}) begin
          r_q <= {5'd0, ws_q};
          c_q <= c_q + 10'd1;
        end else begin
          r_q <= r_q + 9'd1;
        end
      end
      default: ;
    endcase
    if (state_q == E_CWAIT) begin
      acc_q <= '0;
    end else if (vld_q) begin
      acc_q <= acc_q + ScoreW'(sq);
    end
  end

  assign pix_raddr_o = (state_q == E_CRD) ? ctr_addr_q : wa_q;
  assign sc_we_o     = (state_q == E_WRITE);
  assign sc_waddr_o  = ctr_addr_q;
  assign sc_wdata_o  = acc_q;
  assign done_o      = done_q;
  assign max_o       = max_q;

endmodule

[src/window_ssd_corner_marker.sv]
// window_ssd_corner_marker: top level, APB config, load/readout control,
// pixel and score RAMs. Depends on wsc_pkg, wsc_mem, wsc_engine.
`timescale 1ns / 1ps
// Usage:
//  - Configure frame_width (0x0), frame_height (0x4), window_half (0x8) over
//    APB while idle; any write to these registers starts a new frame.
//  - Requests enter on start_i/req_i when busy_o is low. A load request
//    (req_type 0) writes one pixel in raster order.
//  - The last pixel of a frame kicks the score sweep; busy_o stays high
//    until the sweep has scored every interior position. The
//    sweep is bound by the single pixel RAM read port, one pixel a cycle.
//  - A readout request (req_type 1) on a complete frame gives one result
//    on res_o via states T_RADDR, T_RD, T_FIN, flagged by res_valid_o for
//    one cycle; the block takes the next request once that result is out.
//    Readout on an incomplete frame or empty interior gives nothing.
//  - Results cannot be stalled; the receiver must take them when shown.
//  - Reset restores 640x480, half 1, and an empty frame. RAM contents are
//    not cleared; no readout touches an entry not written in this frame.
module window_ssd_corner_marker #(
  parameter int unsigned MAX_WIDTH  = 640,
  parameter int unsigned MAX_HEIGHT = 480,
  parameter int unsigned MAX_HALF   = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              start_i,
  input  wsc_pkg::wsc_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output wsc_pkg::wsc_res_t res_o
);
  import wsc_pkg::*;

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_COMP  = 5'b00010,
    T_RADDR = 5'b00100,
    T_RD    = 5'b01000,
    T_FIN   = 5'b10000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [9:0] w_q;
  logic [8:0] h_q;
  logic [2:0] half_q;
  logic [CW-1:0] load_cnt_q;
  logic [9:0] rd_col_q, col_q;
  logic [8:0] rd_row_q, row_q;
  logic       last_q;
  logic [AW-1:0] addr_q;
  logic       res_valid_q;
  wsc_res_t   res_q;

  logic [9:0] eff_w;
  logic [8:0] eff_h;
  logic [2:0] eff_half;
  logic [3:0] ws;
  logic [CW-1:0] total;
  logic       empty, full, cfg_wr, accept;
  logic [9:0] ncol, rc;
  logic [8:0] nrow, rr;
  logic [CW-1:0] cnt_base;

  wsc_geom_t        geom;
  logic [AW-1:0]    pix_raddr, sc_waddr;
  logic [7:0]       pix_rdata;
  logic             sc_we, eng_done;
  logic [ScoreW-1:0] sc_wdata, sc_rdata, max_score;
  logic             pix_we;

  always_comb begin
    eff_w = w_q;
    if (w_q < 10'd16) eff_w = 10'd16;
    else if (int'(w_q) > MAX_WIDTH) eff_w = 10'(MAX_WIDTH);
    eff_h = h_q;
    if (h_q < 9'd16) eff_h = 9'd16;
    else if (int'(h_q) > MAX_HEIGHT) eff_h = 9'(MAX_HEIGHT);
    eff_half = half_q;
    if (half_q == 3'd0) eff_half = 3'd1;
    else if (int'(half_q) > MAX_HALF) eff_half = 3'(MAX_HALF);
  end

  assign ws    = {eff_half, 1'b1};
  assign total = CW'(eff_w) * CW'(eff_h);
  assign empty = (eff_w <= {5'd0, ws, 1'b0}) || (eff_h <= {4'd0, ws, 1'b0});
  assign full  = (load_cnt_q >= total);
  assign ncol  = eff_w - {5'd0, ws, 1'b0};
  assign nrow  = eff_h - {4'd0, ws, 1'b0};
  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = start_i && !busy_o;

  // a load into a complete frame restarts the frame
  assign cnt_base = full ? '0 : load_cnt_q;
  assign pix_we   = accept && (req_i.req_type == REQ_LOAD);

  // readout position with wrap
  always_comb begin
    rc = rd_col_q;
    rr = rd_row_q;
    if (rd_col_q >= ncol || rd_row_q >= nrow) begin
      rc = '0;
      rr = '0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (req_i.req_type == REQ_LOAD) begin
            if (cnt_base + CW'(1) == total) state_d = T_COMP;
          end else if (full && !empty) begin
            state_d = T_RADDR;
          end
        end
      end
      T_COMP:  if (eng_done) state_d = T_IDLE;
      T_RADDR: state_d = T_RD;
      T_RD:    state_d = T_FIN;
      T_FIN:   state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      w_q         <= 10'd640;
      h_q         <= 9'd480;
      half_q      <= 3'd1;
      load_cnt_q  <= '0;
      rd_col_q    <= '0;
      rd_row_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (state_q == T_FIN);
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_WIDTH:  w_q    <= pwdata[9:0];
          REG_HEIGHT: h_q    <= pwdata[8:0];
          REG_HALF:   half_q <= pwdata[2:0];
          default: ;
        endcase
        if (paddr[3:2] != 2'd3) begin
          load_cnt_q <= '0;
          rd_col_q   <= '0;
          rd_row_q   <= '0;
        end
      end else if (pix_we) begin
        load_cnt_q <= cnt_base + CW'(1);
        if (full) begin
          rd_col_q <= '0;
          rd_row_q <= '0;
        end
      end else if (state_q == T_RADDR) begin
        if (rr + 9'd1 >= nrow) begin
          rd_row_q <= '0;
          rd_col_q <= (rc + 10'd1 >= ncol) ? 10'd0 : rc + 10'd1;
        end else begin
          rd_row_q <= rr + 9'd1;
          rd_col_q <= rc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == T_RADDR) begin
      col_q  <= {6'd0, ws} + rc;
      row_q  <= {5'd0, ws} + rr;
      addr_q <= AW'({5'd0, ws} + rr) * AW'(eff_w) + AW'({6'd0, ws} + rc);
      last_q <= (rc == ncol - 10'd1) && (rr == nrow - 9'd1);
    end
    if (state_q == T_FIN) begin
      res_q.col    <= col_q;
      res_q.row    <= row_q;
      res_q.score  <= sc_rdata;
      res_q.corner <= (27'(sc_rdata) * 27'd5) > (27'(max_score) * 27'd3);
      res_q.last   <= last_q;
    end
  end

  assign geom.start = (state_q == T_IDLE) && (state_d == T_COMP);
  assign geom.w     = eff_w;
  assign geom.h     = eff_h;
  assign geom.half  = eff_half;

  wsc_mem #(.DW(8), .DEPTH(Depth)) u_pix_mem (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (cnt_base[AW-1:0]),
    .wdata_i (req_i.pixel),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  wsc_mem #(.DW(ScoreW), .DEPTH(Depth)) u_score_mem (
    .clk_i   (clk_i),
    .we_i    (sc_we),
    .waddr_i (sc_waddr),
    .wdata_i (sc_wdata),
    .raddr_i (addr_q),
    .rdata_o (sc_rdata)
  );

  wsc_engine #(.AW(AW)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .pix_raddr_o (pix_raddr),
    .pix_rdata_i (pix_rdata),
    .sc_we_o     (sc_we),
    .sc_waddr_o  (sc_waddr),
    .sc_wdata_o  (sc_wdata),
    .done_o      (eng_done),
    .max_o       (max_score)
  );

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {22'd0, w_q};
      REG_HEIGHT: prdata = {23'd0, h_q};
      REG_HALF:   prdata = {29'd0, half_q};
      default:    prdata = '0;
    endcase
  end

  assign pready      = 1'b1;
  assign busy_o      = (state_q != T_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for window_ssd_corner_marker.
// Loads frames, requests readouts, predicts window SSD scores and corner flags.
// Depends on wsc_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_top;
  import wsc_pkg::*;

  localparam int unsigned FrameMaxW = 640;
  localparam int unsigned FrameMaxH = 480;
  localparam int unsigned HalfMax   = 7;
  localparam int unsigned QuietLimit = 20000;

  class corner_scoreboard;
    logic [9:0] width_reg;
    logic [8:0] height_reg;
    logic [2:0] half_reg;
    byte unsigned pix[FrameMaxW*FrameMaxH];
    int unsigned ssd[FrameMaxW*FrameMaxH];
    int unsigned peak, loaded, rd_col, rd_row;
    wsc_res_t pending[$];
    int errors;

    function new();
      width_reg = 640;
      height_reg = 480;
      half_reg = 1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      loaded = 0;
      peak = 0;
      rd_col = 0;
      rd_row = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_WIDTH:  width_reg = v[9:0];
        REG_HEIGHT: height_reg = v[8:0];
        REG_HALF:   half_reg = v[2:0];
        default: return;
      endcase
      restart();
    endfunction

    // geometry after saturation
    function void dims(output int unsigned w, output int unsigned h, output int unsigned k);
      w = (width_reg < 16) ? 16 : (width_reg > FrameMaxW) ? FrameMaxW : width_reg;
      h = (height_reg < 16) ? 16 : (height_reg > FrameMaxH) ? FrameMaxH : height_reg;
      k = (half_reg < 1) ? 1 : (half_reg > HalfMax) ? HalfMax : half_reg;
    endfunction

    function void sweep();
      int unsigned w, h, k, ws, ctr, sum, p, d;
      dims(w, h, k);
      ws = 2 * k + 1;
      peak = 0;
      if (w <= 2 * ws || h <= 2 * ws) return;
      for (int unsigned c = ws; c < w - ws; c++) begin
        for (int unsigned r = ws; r < h - ws; r++) begin
          ctr = pix[r*w+c];
          sum = 0;
          for (int unsigned x = c - k; x <= c + k; x++) begin
            for (int unsigned y = r - k; y <= r + k; y++) begin
              p = pix[y*w+x];
              d = (p > ctr) ? p - ctr : ctr - p;
              sum += d * d;
            end
          end
          sum &= 24'hFFFFFF;
          ssd[r*w+c] = sum;
          if (sum > peak) peak = sum;
        end
      end
    endfunction

    function void note(wsc_req_t rq);
      int unsigned w, h, k, ws, ncol, nrow, c, r, s;
      wsc_res_t e;
      dims(w, h, k);
      ws = 2 * k + 1;
      if (rq.req_type == REQ_LOAD) begin
        if (loaded >= w * h) restart();
        pix[loaded] = rq.pixel;
        loaded++;
        if (loaded == w * h) sweep();
        return;
      end
      if (loaded < w * h) return;
      if (w <= 2 * ws || h <= 2 * ws) return;
      ncol = w - 2 * ws;
      nrow = h - 2 * ws;
      if (rd_col >= ncol || rd_row >= nrow) begin
        rd_col = 0;
        rd_row = 0;
      end
      c = ws + rd_col;
      r = ws + rd_row;
      s = ssd[r*w+c] & 24'hFFFFFF;
      e.col = c[9:0];
      e.row = r[8:0];
      e.score = s[23:0];
      e.corner = (5 * longint'(s) > 3 * longint'(peak));
      e.last = (rd_col == ncol - 1 && rd_row == nrow - 1);
      pending = {pending, e};
      rd_row++;
      if (rd_row >= nrow) begin
        rd_row = 0;
        rd_col++;
        if (rd_col >= ncol) rd_col = 0;
      end
    endfunction

    function void check(wsc_res_t got);
      wsc_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.col !== e.col || got.row !== e.row || got.score !== e.score ||
          got.corner !== e.corner || got.last !== e.last) begin
        $display("%0t: mismatch expected col=%0d row=%0d score=%0d corner=%0b last=%0b",
                 $time, e.col, e.row, e.score, e.corner, e.last);
        $display("%0t:          actual col=%0d row=%0d score=%0d corner=%0b last=%0b",
                 $time, got.col, got.row, got.score, got.corner, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic start_i, busy_o, res_valid_o;
  wsc_req_t req_i;
  wsc_res_t res_o;

  corner_scoreboard sb = new();
  int idle_pct;
  int unsigned quiet = 0;
  int unsigned accepted = 0;

  window_ssd_corner_marker uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start_i, .req_i, .busy_o, .res_valid_o, .res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        sb.note(req_i);
        accepted++;
      end
      if (res_valid_o) sb.check(res_o);
      if ((start_i && !busy_o) || res_valid_o || (psel && penable)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet == QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(logic kind, logic [7:0] value);
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{req_type: kind, pixel: value};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // drain results and let the score sweep finish
  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned k);
    settle();
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
    reg_write(REG_HALF, k);
  endtask

  // pattern: 0 random, 1 alternating 0/255 with phase flip every 32 pixels, 2 mostly flat
  task automatic load_frame(int unsigned n, int pattern);
    logic [7:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      case (pattern)
        1: v = ((i + i / 32) % 2) ? 8'd255 : 8'd0;
        2: v = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd128;
        default: v = 8'($urandom);
      endcase
      send(REQ_LOAD, v);
    end
  endtask

  task automatic readouts(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send(REQ_READ, 8'($urandom));
  endtask

  task automatic random_frames(int unsigned quota, bit hold_once);
    int unsigned w, h, k, base, reads;
    base = accepted;
    sb.dims(w, h, k);
    while (accepted - base < quota) begin
      if ($urandom_range(0, 9) < 7) begin
        w = $urandom_range(16, 18);
        h = $urandom_range(16, 17);
        k = $urandom_range(1, 2);
        setup(w, h, k);
      end
      if ($urandom_range(0, 3) == 0) readouts(1);
      load_frame(w * h, $urandom_range(0, 2));
      reads = $urandom_range(5, 40);
      readouts(reads / 2);
      if (hold_once) begin
        start_i <= 1'b0;
        @(posedge clk_i);
        while (sb.pending.size() != 0) @(posedge clk_i);
        hold_once = 0;
      end
      readouts(reads - reads / 2);
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start_i = 1'b0; req_i = '0;
    idle_pct = 18;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty interior at the largest window
    setup(16, 16, 7);
    load_frame(256, 0);
    readouts(2);
    // out-of-range geometry saturates to 16x16, half 1; readout before
    // completion, then wrap past the last position
    setup(5, 3, 0);
    load_frame(100, 1);
    readouts(1);
    load_frame(156, 0);
    readouts(105);

    idle_pct = 71;
    random_frames(1, 0);
    idle_pct = 0;
    random_frames(1, 1);

    start_i <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
